/* hw/rtl/stb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg : shared constants for the soft timer bank
// Bank size, derived index width, command codes, result kinds and status bits.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_DISABLE = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam int ENABLEBIT = 7;
  localparam int MODEBIT   = 1;
  localparam int RUNBIT    = 0;

  function automatic logic [7:0] status_of(input logic en, input logic os, input logic run);
    logic [7:0] s;
    s            = '0;
    s[ENABLEBIT] = en;
    s[MODEBIT]   = os;
    s[RUNBIT]    = run;
    return s;
  endfunction

endpackage

/* hw/rtl/soft_timer_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_timer_bank : bank of down-counting software timers
// Commands and ticks come in one word at a time; expiry signals and query
// replies go out through a registered result word.
// ----------------------------------------------------------------------------
// One input word is taken at a time; in_stall is high while it is worked on.
// A command (set, start, stop, disable, query) has an accept step and an
// execute step, which a query stretches while the result word is still held
// by out_stall. A tick is accepted and then scans every timer through a
// single shared 16-bit incrementer/decrementer: a timer that is idle or just
// counts down takes a scan step, one that expires without a semaphore a scan
// and a reload step, one that expires and signals a scan, a reload and an emit
// step (the emit waits while the result word is stalled). Ignored words
// (unknown opcode, timer id out of range) are accepted and dropped in idle.
// ----------------------------------------------------------------------------

module soft_timer_bank
  import stb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command / tick word
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [2:0]  timer_id,
  input  logic [15:0] period_value,
  input  logic        one_shot,
  input  logic [7:0]  signal_id,
  // result word
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reply_kind,
  output logic [2:0]  which_timer,
  output logic [7:0]  signalled_id,
  output logic [7:0]  status_byte,
  output logic [15:0] period_tally,
  output logic        last_of_run
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_RELOAD,
    ST_EMIT
  } state_t;

  state_t state;

  // Per-timer state, small enough for flops
  logic [15:0] reload_period [NUM_TIMERS];
  logic [15:0] down_count    [NUM_TIMERS];
  logic [15:0] expiry_tally  [NUM_TIMERS];
  logic [7:0]  notify_id     [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] enabled_flag;
  logic [NUM_TIMERS-1:0] running_flag;
  logic [NUM_TIMERS-1:0] oneshot_flag;

  // Latched command word
  logic [2:0]  op;
  logic [15:0] period;
  logic        mode;
  logic [7:0]  sig;

  logic [IDX_W-1:0]      cur;        // timer under work
  logic [NUM_TIMERS-1:0] emit_mask;  // timers that will signal on this tick

  logic        accept;
  logic        id_ok;
  logic        out_free;
  logic        out_load;
  logic        cur_zero;
  logic        cur_last;
  logic        later_emit;
  logic [15:0] alu_a;
  logic        alu_inc;
  logic [15:0] alu_y;
  logic [NUM_TIMERS-1:0] emit_mask_next;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign id_ok    = (timer_id != 3'd0) && (32'(timer_id) <= NUM_TIMERS);
  assign out_free = !out_valid || !out_stall;
  // result register loads this cycle
  assign out_load = out_free && ((state == ST_CMD && op == OP_QUERY) || state == ST_EMIT);
  assign cur_zero = (down_count[cur] == 16'd0);
  assign cur_last = (cur == IDX_W'(NUM_TIMERS - 1));
  assign later_emit = ((emit_mask >> cur) >> 1) != '0;

  // Which timers will expire and signal, known at the start of the tick:
  // each timer's outcome depends only on its own state.
  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) begin
      emit_mask_next[t] = enabled_flag[t] && running_flag[t] &&
                          (down_count[t] == 16'd0) && (notify_id[t] != 8'd0);
    end
  end

  // Shared incrementer / decrementer
  always_comb begin
    alu_a   = down_count[cur];
    alu_inc = 1'b0;
    case (state)
      ST_CMD: begin
        alu_a = period;
      end
      ST_SCAN: begin
        if (cur_zero) begin
          alu_a   = expiry_tally[cur];
          alu_inc = 1'b1;
        end
      end
      ST_RELOAD: begin
        alu_a = reload_period[cur];
      end
      default: begin
        alu_a = down_count[cur];
      end
    endcase
    alu_y = alu_a + (alu_inc ? 16'h0001 : 16'hFFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur          <= '0;
      emit_mask    <= '0;
      out_valid    <= 1'b0;
      enabled_flag <= '0;
      running_flag <= '0;
      oneshot_flag <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        reload_period[t] <= '0;
        down_count[t]    <= '0;
        expiry_tally[t]  <= '0;
        notify_id[t]     <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            op     <= opcode;
            period <= period_value;
            mode   <= one_shot;
            sig    <= signal_id;
            if (opcode == OP_TICK) begin
              cur       <= '0;
              emit_mask <= emit_mask_next;
              state     <= ST_SCAN;
            end else if (id_ok && (opcode == OP_SET || opcode == OP_START ||
                                   opcode == OP_STOP || opcode == OP_DISABLE ||
                                   opcode == OP_QUERY)) begin
              cur   <= IDX_W'(32'(timer_id) - 1);
              state <= ST_CMD;
            end
          end
        end

        ST_CMD: begin
          case (op)
            OP_SET: begin
              reload_period[cur] <= period;
              down_count[cur]    <= alu_y;
              running_flag[cur]  <= 1'b0;
              oneshot_flag[cur]  <= mode;
              expiry_tally[cur]  <= '0;
              notify_id[cur]     <= sig;
              enabled_flag[cur]  <= 1'b1;
              state              <= ST_IDLE;
            end
            OP_START: begin
              running_flag[cur] <= 1'b1;
              state             <= ST_IDLE;
            end
            OP_STOP: begin
              running_flag[cur] <= 1'b0;
              state             <= ST_IDLE;
            end
            OP_DISABLE: begin
              enabled_flag[cur] <= 1'b0;
              state             <= ST_IDLE;
            end
            OP_QUERY: begin
              if (out_free) begin
                reply_kind   <= KIND_QUERY;
                which_timer  <= 3'(32'(cur) + 1);
                signalled_id <= '0;
                status_byte  <= status_of(enabled_flag[cur], oneshot_flag[cur],
                                          running_flag[cur]);
                period_tally <= expiry_tally[cur];
                last_of_run  <= 1'b1;
                state        <= ST_IDLE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end

        ST_SCAN: begin
          if (enabled_flag[cur] && running_flag[cur]) begin
            if (!cur_zero) begin
              down_count[cur] <= alu_y;
              if (cur_last) begin
                state <= ST_IDLE;
              end else begin
                cur <= cur + 1'b1;
              end
            end else begin
              // expiry: bump tally now, reload next cycle
              expiry_tally[cur] <= alu_y;
              if (oneshot_flag[cur]) begin
                running_flag[cur] <= 1'b0;
              end
              state <= ST_RELOAD;
            end
          end else if (cur_last) begin
            state <= ST_IDLE;
          end else begin
            cur <= cur + 1'b1;
          end
        end

        ST_RELOAD: begin
          down_count[cur] <= alu_y;
          if (notify_id[cur] != 8'd0) begin
            state <= ST_EMIT;
          end else if (cur_last) begin
            state <= ST_IDLE;
          end else begin
            cur   <= cur + 1'b1;
            state <= ST_SCAN;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            reply_kind   <= KIND_EXPIRY;
            which_timer  <= 3'(32'(cur) + 1);
            signalled_id <= notify_id[cur];
            status_byte  <= status_of(enabled_flag[cur], oneshot_flag[cur],
                                      running_flag[cur]);
            period_tally <= expiry_tally[cur];
            last_of_run  <= !later_emit;
            if (cur_last) begin
              state <= ST_IDLE;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_SCAN;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_query_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind == KIND_QUERY |-> last_of_run)
    else $error("query reply not marked last");

  a_expiry_sig: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind == KIND_EXPIRY |-> signalled_id != 8'd0)
    else $error("expiry result with no semaphore");

  a_timer_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> which_timer != 3'd0 && 32'(which_timer) <= NUM_TIMERS)
    else $error("result names a timer outside the bank");

  a_emit_planned: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> emit_mask[cur])
    else $error("expiry signal not in the tick's emit plan");

endmodule
